### hdl/global_edf_multiprocessor_scheduler_top_assert.svh
// ----------------------------------------------------------------------------
// EDF scheduler assertion macros
// Concurrent assertion wrappers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GLOBAL_EDF_MULTIPROCESSOR_SCHEDULER_TOP_ASSERT_SVH
`define GLOBAL_EDF_MULTIPROCESSOR_SCHEDULER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define EDF_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define EDF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define EDF_ASSERT(label, cond, msg)

`define EDF_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

### hdl/edf_pkg.sv
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared constants, types and the candidate ordering function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edf_pkg;

  localparam int NUM_CPUS  = 3;
  localparam int MAX_JOBS  = 16;
  localparam int TIME_W    = 16;
  localparam int CPU_W     = 2;
  localparam int SLOT_W    = $clog2(MAX_JOBS);
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int SCAN_LEN  = MAX_JOBS + NUM_CPUS - 1;
  localparam int SCAN_W    = $clog2(SCAN_LEN);
  localparam int IN_W      = 56;
  localparam int OUT_W     = 32;

  localparam logic [TIME_W-1:0] LIMIT_RST = 16'd200;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] dl;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] rem;
  } cand_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] rel;
    logic [TIME_W-1:0] dl;
    logic [TIME_W-1:0] work;
  } load_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] rem;
  } upd_t;

  // earlier deadline wins, equal deadline goes to the lower slot
  function automatic logic better(input cand_t a, input cand_t b);
    logic res;
    res = a.vld && (!b.vld || ({a.dl, a.slot} < {b.dl, b.slot}));
    return res;
  endfunction

endpackage

### hdl/edf_cell.sv
// ----------------------------------------------------------------------------
// EDF sort cell
// Keeps the best candidate seen, forwards the loser to the next cell;
// shifts toward cell 0 while results are drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edf_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  edf_pkg::cell_ctl_t ctl_i,
  input  edf_pkg::cand_t    cand_i,
  input  edf_pkg::cand_t    shift_i,
  output edf_pkg::cand_t    held_o,
  output edf_pkg::cand_t    fwd_o
);
  import edf_pkg::*;

  cand_t held_q, held_d;
  cand_t fwd_q, fwd_d;

  always_comb begin
    held_d = held_q;
    fwd_d  = fwd_q;
    if (ctl_i.clear) begin
      held_d = '0;
      fwd_d  = '0;
    end else if (ctl_i.insert) begin
      if (better(cand_i, held_q)) begin
        held_d = cand_i;
        fwd_d  = held_q;
      end else begin
        fwd_d  = cand_i;
      end
    end else if (ctl_i.shift) begin
      held_d = shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      fwd_q  <= '0;
    end else begin
      held_q <= held_d;
      fwd_q  <= fwd_d;
    end
  end

  assign held_o = held_q;
  assign fwd_o  = fwd_q;

endmodule

### hdl/edf_job_table.sv
// ----------------------------------------------------------------------------
// EDF job table
// Release, deadline and remaining work per slot, active flags and the
// count of unfinished jobs; one slot read per cycle for the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "global_edf_multiprocessor_scheduler_top_assert.svh"

module edf_job_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  edf_pkg::load_t              load_i,
  input  edf_pkg::upd_t               upd_i,
  input  logic                        rd_en_i,
  input  logic [edf_pkg::SLOT_W-1:0]  rd_idx_i,
  input  logic [edf_pkg::TIME_W-1:0]  time_i,
  output edf_pkg::cand_t              cand_o,
  output logic [edf_pkg::CNT_W-1:0]   unfinished_o
);
  import edf_pkg::*;

  logic [TIME_W-1:0]   rel_q [MAX_JOBS];
  logic [TIME_W-1:0]   dl_q  [MAX_JOBS];
  logic [TIME_W-1:0]   rem_q [MAX_JOBS];
  logic [MAX_JOBS-1:0] active_q, active_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (load_i.en) begin
      active_d[load_i.slot] = (load_i.work != '0);
      cnt_d = cnt_q - CNT_W'(active_q[load_i.slot]) + CNT_W'(load_i.work != '0);
    end else if (upd_i.en && (upd_i.rem == '0)) begin
      active_d[upd_i.slot] = 1'b0;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.en) begin
      rel_q[load_i.slot] <= load_i.rel;
      dl_q[load_i.slot]  <= load_i.dl;
      rem_q[load_i.slot] <= load_i.work;
    end else if (upd_i.en) begin
      rem_q[upd_i.slot]  <= upd_i.rem;
    end
  end

  always_comb begin
    cand_o.vld  = rd_en_i && active_q[rd_idx_i] && (rel_q[rd_idx_i] <= time_i);
    cand_o.dl   = dl_q[rd_idx_i];
    cand_o.slot = rd_idx_i;
    cand_o.rem  = rem_q[rd_idx_i];
  end

  assign unfinished_o = cnt_q;

  `EDF_ASSERT(cnt_matches_active, $countones(active_q) == int'(cnt_q), "unfinished count off")
  `EDF_ASSERT_IMPL(no_load_and_update, load_i.en, !upd_i.en, "load collides with update")

endmodule

### hdl/global_edf_multiprocessor_scheduler_top.sv
// Flow: a tick scans every table slot through the sort cells, then emits one result
// per cpu, holding while m_axis_tready is low. A halted tick emits one halted result;
// a load emits none. One item at a time; the scan is set by the single table read
// port visiting one slot per cycle.
// Reset: asynchronous, active low; clears the job table's active flags and count, time,
// counters and cells; time_limit returns to 200.
// ----------------------------------------------------------------------------
// Global EDF multiprocessor scheduler
// Loads jobs into a slot table and, per tick, picks the earliest-deadline
// ready jobs for each cpu through a chain of sort cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "global_edf_multiprocessor_scheduler_top_assert.svh"

module global_edf_multiprocessor_scheduler_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [edf_pkg::TIME_W-1:0]  cfg_wr_data_i,   // time_limit
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // job_slot[3:0], release_time[19:4], work_ticks[35:20], deadline_time[51:36]
  input  logic [edf_pkg::IN_W-1:0]    s_axis_tdata,
  input  logic                        s_axis_tuser,    // func
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // cpu_index[1:0], job_index[5:2], cpu_idle[6], job_finished[7],
  // finish_time[23:8], deadline_met[24]
  output logic [edf_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                        m_axis_tuser,    // halted
  output logic                        m_axis_tlast     // last_result
);
  import edf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic [CPU_W-1:0]  emit_q, emit_d;
  logic              halt_q, halt_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TIME_W-1:0] limit_q;

  logic              out_vld_q, out_vld_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;
  logic              out_user_q, out_user_d;
  logic              out_last_q, out_last_d;

  logic              in_fire, step, running, last_cpu;
  logic [CNT_W-1:0]  unfinished;
  cand_t             tbl_cand, head;
  cand_t             held [NUM_CPUS];
  cand_t             fwd  [NUM_CPUS];
  cell_ctl_t         ctl;
  load_t             load;
  upd_t              upd;

  logic [TIME_W-1:0] ft, rem_dec;
  logic              fin, met;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign running       = (unfinished != '0) && (time_q < limit_q);
  assign step          = (state_q == ST_EMIT) && (!out_vld_q || m_axis_tready);
  assign last_cpu      = (emit_q == CPU_W'(NUM_CPUS - 1));

  assign head    = held[0];
  assign rem_dec = head.rem - TIME_W'(1);
  assign fin     = head.vld && (head.rem == TIME_W'(1));
  assign ft      = time_q + TIME_W'(1);
  assign met     = fin && (ft <= head.dl);

  always_comb begin
    load.en   = in_fire && (s_axis_tuser == FUNC_LOAD);
    load.slot = s_axis_tdata[SLOT_W-1:0];
    load.rel  = s_axis_tdata[19:4];
    load.work = s_axis_tdata[35:20];
    load.dl   = s_axis_tdata[51:36];

    upd.en    = step && !halt_q && head.vld;
    upd.slot  = head.slot;
    upd.rem   = rem_dec;

    ctl.clear  = in_fire && (s_axis_tuser != FUNC_LOAD) && running;
    ctl.insert = (state_q == ST_SCAN);
    ctl.shift  = step && !halt_q;
  end

  edf_job_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .upd_i        (upd),
    .rd_en_i      ((state_q == ST_SCAN) && (scan_q < SCAN_W'(MAX_JOBS))),
    .rd_idx_i     (scan_q[SLOT_W-1:0]),
    .time_i       (time_q),
    .cand_o       (tbl_cand),
    .unfinished_o (unfinished)
  );

  for (genvar k = 0; k < NUM_CPUS; k++) begin : g_cell
    cand_t cin, sin;
    if (k == 0) begin : g_first
      assign cin = tbl_cand;
    end else begin : g_rest
      assign cin = fwd[k-1];
    end
    if (k == NUM_CPUS - 1) begin : g_end
      assign sin = '0;
    end else begin : g_mid
      assign sin = held[k+1];
    end
    edf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .cand_i  (cin),
      .shift_i (sin),
      .held_o  (held[k]),
      .fwd_o   (fwd[k])
    );
  end

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    emit_d     = emit_q;
    halt_d     = halt_q;
    time_d     = time_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    out_last_d = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (s_axis_tuser != FUNC_LOAD)) begin
          halt_d = !running;
          emit_d = '0;
          scan_d = '0;
          state_d = running ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + SCAN_W'(1);
        if (scan_q == SCAN_W'(SCAN_LEN - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (step) begin
          out_vld_d = 1'b1;
          if (halt_q) begin
            out_data_d = '0;
            out_user_d = 1'b1;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            out_data_d = {7'b0, met, (fin ? ft : TIME_W'(0)), fin, !head.vld,
                          (head.vld ? head.slot : SLOT_W'(0)), emit_q};
            out_user_d = 1'b0;
            out_last_d = last_cpu;
            if (last_cpu) begin
              time_d  = ft;
              state_d = ST_IDLE;
            end else begin
              emit_d = emit_q + CPU_W'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      emit_q    <= '0;
      halt_q    <= 1'b0;
      time_q    <= '0;
      limit_q   <= LIMIT_RST;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      emit_q    <= emit_d;
      halt_q    <= halt_d;
      time_q    <= time_d;
      out_vld_q <= out_vld_d;
      if (cfg_wr_en_i) begin
        limit_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  `EDF_ASSERT_IMPL(time_moves_on_last, time_q != $past(time_q), m_axis_tvalid && m_axis_tlast && !m_axis_tuser, "time advanced without a closing result")
  `EDF_ASSERT_IMPL(halt_result_clean, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "halted result carries data")
  `EDF_ASSERT_IMPL(idle_cpu_no_finish, m_axis_tvalid && m_axis_tdata[6], !m_axis_tdata[7] && (m_axis_tdata[5:2] == '0), "idle cpu reports a job")

endmodule

### tb/global_edf_multiprocessor_scheduler_top_test.sv
// ----------------------------------------------------------------------------
// EDF scheduler testbench
// Drives load and tick items into the scheduler and checks every per-cpu
// result against an in-bench EDF predictor. A short table covers halting,
// ties, misses, idle cpus and the time limit; random phases with fresh limits
// follow, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module global_edf_multiprocessor_scheduler_top_test;
  import edf_pkg::*;

  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 240;
  localparam int TABLE_ROWS    = 23;

  typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_LIMIT} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [3:0]        slot;
    logic [TIME_W-1:0] rel;
    logic [TIME_W-1:0] work;
    logic [TIME_W-1:0] dl;
    logic [TIME_W-1:0] limit;
    logic              halt_typed;
  } stim_row_t;

  typedef struct packed {
    logic [1:0]        cpu;
    logic [3:0]        job;
    logic              idle;
    logic              fin;
    logic [TIME_W-1:0] ftime;
    logic              met;
    logic              halted;
    logic              last;
  } cpu_report_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_wr_en_i;
  logic [TIME_W-1:0] cfg_wr_data_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  global_edf_multiprocessor_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // scheduler mirror
  logic [TIME_W-1:0] release_at     [MAX_JOBS];
  logic [TIME_W-1:0] deadline_at    [MAX_JOBS];
  logic [TIME_W-1:0] remaining_work [MAX_JOBS];
  logic [TIME_W-1:0] now_tick;
  logic [TIME_W-1:0] tick_limit;
  cpu_report_t       step_reports [NUM_CPUS];
  cpu_report_t       cpu_reports_q [$];

  int errors;
  int items_sent;
  int loads_sent;
  int ticks_sent;
  int halted_seen;
  int jobs_done;
  int late_jobs;
  int limit_writes;
  bit fast_phase;

  stim_row_t directed_rows [TABLE_ROWS] = '{
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b1},
    '{ROW_LOAD,  4'd0,  16'h0000, 16'h0001, 16'hFFFF, 16'd0,     1'b0},
    '{ROW_LOAD,  4'd15, 16'h0000, 16'h0002, 16'hFFFF, 16'd0,     1'b0},
    '{ROW_LOAD,  4'd5,  16'hFFFF, 16'hFFFF, 16'h0000, 16'd0,     1'b0},
    '{ROW_LOAD,  4'd3,  16'h0000, 16'h0001, 16'h0000, 16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b0},
    '{ROW_LOAD,  4'd5,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b1},
    '{ROW_LIMIT, 4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd1,     1'b0},
    '{ROW_LOAD,  4'd7,  16'h0000, 16'h0003, 16'd10,   16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b1},
    '{ROW_LIMIT, 4'd0,  16'h0000, 16'h0000, 16'h0000, 16'hFFFF,  1'b0},
    '{ROW_LOAD,  4'd8,  16'd3,    16'h0002, 16'd5,    16'd0,     1'b0},
    '{ROW_LOAD,  4'd9,  16'h0000, 16'h0001, 16'd5,    16'd0,     1'b0},
    '{ROW_LOAD,  4'd1,  16'h0000, 16'h0002, 16'd4,    16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b0},
    '{ROW_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 16'd0,     1'b1},
    '{ROW_LIMIT, 4'd0,  16'h0000, 16'h0000, 16'h0000, LIMIT_RST, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // returns the number of results the item causes, left in step_reports
  function automatic int step_scheduler(input logic func, input logic [3:0] slot,
                                        input logic [TIME_W-1:0] rel,
                                        input logic [TIME_W-1:0] work,
                                        input logic [TIME_W-1:0] dl);
    logic              taken [MAX_JOBS];
    int                best;
    int                busy;
    cpu_report_t       r;
    logic [TIME_W-1:0] ft;
    busy = 0;
    foreach (remaining_work[i]) if (remaining_work[i] != 0) busy++;
    if (func == FUNC_LOAD) begin
      release_at[slot]     = rel;
      deadline_at[slot]    = dl;
      remaining_work[slot] = work;
      return 0;
    end
    if (busy == 0 || now_tick >= tick_limit) begin
      r = '0;
      r.halted = 1'b1;
      r.last = 1'b1;
      step_reports[0] = r;
      return 1;
    end
    foreach (taken[i]) taken[i] = 1'b0;
    for (int c = 0; c < NUM_CPUS; c++) begin
      best = -1;
      for (int i = 0; i < MAX_JOBS; i++) begin
        if (!taken[i] && remaining_work[i] != 0 && release_at[i] <= now_tick) begin
          if (best < 0 || deadline_at[i] < deadline_at[best]) best = i;
        end
      end
      r = '0;
      r.cpu = c[1:0];
      r.last = (c == NUM_CPUS - 1);
      if (best < 0) begin
        r.idle = 1'b1;
      end else begin
        taken[best] = 1'b1;
        remaining_work[best] = remaining_work[best] - 1'b1;
        r.job = best[3:0];
        if (remaining_work[best] == 0) begin
          ft = now_tick + 1'b1;
          r.fin = 1'b1;
          r.ftime = ft;
          r.met = (ft <= deadline_at[best]);
        end
      end
      step_reports[c] = r;
    end
    now_tick = now_tick + 1'b1;
    return NUM_CPUS;
  endfunction

  // starts and ends at a falling edge; tvalid stays high after the accept
  task automatic send_item(input logic func, input logic [3:0] slot,
                           input logic [TIME_W-1:0] rel, input logic [TIME_W-1:0] work,
                           input logic [TIME_W-1:0] dl, input logic halt_typed);
    int          gap;
    int          n;
    cpu_report_t halt_rep;
    gap = fast_phase ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{(IN_W - 52){1'b0}}, dl, work, rel, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    n = step_scheduler(func, slot, rel, work, dl);
    if (halt_typed) begin
      halt_rep = '0;
      halt_rep.halted = 1'b1;
      halt_rep.last = 1'b1;
      cpu_reports_q = {cpu_reports_q, halt_rep};
      halted_seen++;
    end else begin
      for (int k = 0; k < n; k++) begin
        cpu_reports_q = {cpu_reports_q, step_reports[k]};
        if (step_reports[k].halted) halted_seen++;
        if (step_reports[k].fin) begin
          jobs_done++;
          if (!step_reports[k].met) late_jobs++;
        end
      end
    end
    if (func == FUNC_LOAD) loads_sent++;
    else ticks_sent++;
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (cpu_reports_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [TIME_W-1:0] value);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    tick_limit = value;
    limit_writes++;
  endtask

  task automatic clear_busy_slots();
    for (int s = 0; s < MAX_JOBS; s++) begin
      if (remaining_work[s] != 0)
        send_item(FUNC_LOAD, s[3:0], 16'($urandom), '0, 16'($urandom), 1'b0);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result side
  initial begin
    int          stall;
    cpu_report_t want;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = fast_phase ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (cpu_reports_q.size() == 0) begin
        $display("%0t ns: unexpected item, tdata %h tuser %b tlast %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = cpu_reports_q.pop_front();
        check_field("cpu_index",    want.cpu,    m_axis_tdata[1:0]);
        check_field("job_index",    want.job,    m_axis_tdata[5:2]);
        check_field("cpu_idle",     want.idle,   m_axis_tdata[6]);
        check_field("job_finished", want.fin,    m_axis_tdata[7]);
        check_field("finish_time",  want.ftime,  m_axis_tdata[23:8]);
        check_field("deadline_met", want.met,    m_axis_tdata[24]);
        check_field("halted",       want.halted, m_axis_tuser);
        check_field("last_result",  want.last,   m_axis_tlast);
      end
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int                random_goal;
    int                pick;
    logic [3:0]        slot;
    logic [TIME_W-1:0] rel;
    logic [TIME_W-1:0] work;
    stim_row_t         row;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    errors = 0;
    items_sent = 0;
    loads_sent = 0;
    ticks_sent = 0;
    halted_seen = 0;
    jobs_done = 0;
    late_jobs = 0;
    limit_writes = 0;
    fast_phase = 1'b0;
    foreach (remaining_work[i]) begin
      release_at[i] = '0;
      deadline_at[i] = '0;
      remaining_work[i] = '0;
    end
    now_tick = '0;
    tick_limit = LIMIT_RST;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_LIMIT) begin
        drain_reports();
        write_limit(row.limit);
      end else begin
        send_item((row.kind == ROW_TICK) ? FUNC_TICK : FUNC_LOAD, row.slot, row.rel,
                  row.work, row.dl, row.halt_typed);
      end
    end

    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      drain_reports();
      if ($urandom_range(0, 3) == 0) write_limit(16'hFFFF);
      else write_limit(now_tick + 16'($urandom_range(5, 60)));
      fast_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) clear_busy_slots();
      for (int k = 0; k < 40 && items_sent < random_goal; k++) begin
        pick = $urandom_range(0, 99);
        slot = 4'($urandom);
        if (pick < 55) begin
          send_item(FUNC_TICK, slot, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        end else if (pick < 85) begin
          rel  = now_tick + 16'($urandom_range(0, 4));
          work = 16'($urandom_range(1, 6));
          send_item(FUNC_LOAD, slot, rel, work,
                    rel + work + 16'($urandom_range(0, 12)) - 16'd3, 1'b0);
        end else if (pick < 93) begin
          send_item(FUNC_LOAD, slot, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        end else if (pick < 96) begin
          send_item(FUNC_LOAD, slot, 16'($urandom), '0, 16'($urandom), 1'b0);
        end else begin
          drain_reports();
        end
      end
    end

    drain_reports();
    $display("Sent %0d loads and %0d ticks across %0d time limit settings",
             loads_sent, ticks_sent, limit_writes);
    $display("Saw %0d jobs complete (%0d late) and %0d halted ticks",
             jobs_done, late_jobs, halted_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
